>>> hw/rtl/sptt_pkg.sv
package sptt_pkg;

  // Store geometry
  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned INDEX_BITS  = 12;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TERM_W      = 2 * INDEX_BITS + VALUE_W;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    logic                        has_term;
    logic [INDEX_BITS-1:0]       in_row;
    logic [INDEX_BITS-1:0]       in_col;
    logic signed [VALUE_W-1:0]   in_value;
    logic                        last_term;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]       out_row;
    logic [INDEX_BITS-1:0]       out_col;
    logic signed [VALUE_W-1:0]   out_value;
    logic                        last_out;
    logic                        overflow;
  } out_item_t;

  // One stored term, as laid out in the RAM word
  typedef struct packed {
    logic [INDEX_BITS-1:0]       row;
    logic [INDEX_BITS-1:0]       col;
    logic signed [VALUE_W-1:0]   value;
  } term_t;

endpackage

>>> hw/rtl/sparse_triplet_transpose.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------
// in       | sink      | in_valid_i / in_stall_o | in_item_i  (sptt_pkg::in_item_t)
// out      | source    | out_valid_o/out_stall_i | out_item_o (sptt_pkg::out_item_t)
// cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Loading accepts one item per cycle. The item marked last starts the scan, during
// which in_stall_o is high. The scan makes one pass per distinct stored column
// below source_cols (plus one for column 0 if it holds no term); each pass reads
// every stored term through the single RAM read port, and a closing flush step
// follows. Output stalls lengthen the scan.
// Reset clears the state, count, indices and flags only; the term RAM needs no clearing pass.
module sparse_triplet_transpose (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sptt_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sptt_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sptt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sptt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import sptt_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_RD    = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  dropped_q, dropped_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [INDEX_BITS-1:0] cur_col_q, cur_col_d;
  logic [INDEX_BITS-1:0] next_col_q, next_col_d;
  logic                  next_found_q, next_found_d;
  logic                  held_valid_q, held_valid_d;
  term_t                 held_q, held_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic [CFG_DATA_W-1:0] source_cols_q;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [TERM_W-1:0]     ram_wdata;
  logic [TERM_W-1:0]     ram_rdata;
  term_t                 entry;
  term_t                 in_term;
  logic                  out_free;
  logic                  match;

  // Configuration: always ready. The user must keep it only written while idle;
  // the block has no check. The source row count does not steer the scan and is not kept.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_cols_q <= CFG_DATA_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SOURCE_COLS: source_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Term store
  sptt_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_term.row   = in_item_i.in_row;
  assign in_term.col   = in_item_i.in_col;
  assign in_term.value = in_item_i.in_value;
  assign ram_wdata     = in_term;
  assign ram_waddr     = count_q[ADDR_W-1:0];
  assign ram_raddr     = idx_q[ADDR_W-1:0];
  assign entry         = term_t'(ram_rdata);
  assign match         = (entry.col == cur_col_q);

  assign in_stall_o = (state_q != S_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: load, then per-column passes over the store, then a flush
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dropped_d    = dropped_q;
    idx_d        = idx_q;
    cur_col_d    = cur_col_q;
    next_col_d   = next_col_q;
    next_found_d = next_found_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i && in_item_i.has_term) begin
          if (count_q < CNT_W'(MAX_ENTRIES)) begin
            ram_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            dropped_d = 1'b1;
          end
        end
        if (in_valid_i && in_item_i.last_term) begin
          cur_col_d    = '0;
          idx_d        = '0;
          next_found_d = 1'b0;
          if (count_d == '0 || source_cols_q == '0) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_RD;
          end
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        // A new match needs the held term moved out first
        if (!(match && held_valid_q && !out_free)) begin
          if (match) begin
            if (held_valid_q) begin
              out_valid_d       = 1'b1;
              out_d.out_row     = held_q.col;
              out_d.out_col     = held_q.row;
              out_d.out_value   = held_q.value;
              out_d.last_out    = 1'b0;
              out_d.overflow    = dropped_q;
            end
            held_d       = entry;
            held_valid_d = 1'b1;
          end
          // Track the smallest column above the current one
          if (entry.col > cur_col_q && (!next_found_q || entry.col < next_col_q)) begin
            next_col_d   = entry.col;
            next_found_d = 1'b1;
          end
          if (idx_q + CNT_W'(1) == count_q) begin
            if (next_found_d && {1'b0, next_col_d} < source_cols_q) begin
              cur_col_d    = next_col_d;
              next_found_d = 1'b0;
              idx_d        = '0;
              state_d      = S_RD;
            end else begin
              state_d = S_FLUSH;
            end
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_RD;
          end
        end
      end

      S_FLUSH: begin
        // Final held term goes out marked last; then the store empties
        if (!held_valid_q || out_free) begin
          if (held_valid_q) begin
            out_valid_d     = 1'b1;
            out_d.out_row   = held_q.col;
            out_d.out_col   = held_q.row;
            out_d.out_value = held_q.value;
            out_d.last_out  = 1'b1;
            out_d.overflow  = dropped_q;
          end
          held_valid_d = 1'b0;
          count_d      = '0;
          dropped_d    = 1'b0;
          state_d      = S_LOAD;
        end
      end

      default: state_d = S_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      idx_q        <= '0;
      cur_col_q    <= '0;
      next_found_q <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      dropped_q    <= dropped_d;
      idx_q        <= idx_d;
      cur_col_q    <= cur_col_d;
      next_found_q <= next_found_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    next_col_q <= next_col_d;
    held_q     <= held_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("term count above store depth");

  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !held_valid_q)
    else $error("held term left over after a run");

  a_col_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_EVAL) |-> {1'b0, cur_col_q} < source_cols_q)
    else $error("scan column outside source_cols");

  a_idx_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_EVAL) |-> idx_q < count_q)
    else $error("read of an unfilled store entry");

endmodule

>>> hw/rtl/sptt_ram.sv
module sptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds without re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/sv/tb_sparse_triplet_transpose.sv
module tb_sparse_triplet_transpose;
  import sptt_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned OVERFLOW_RUN  = MAX_ENTRIES + 2;

  // Indexes with no register behind them: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Receiver stall: short per-transfer waits plus the long hold-off
  logic                  recv_stall  = 1'b0;
  logic                  hold_stall  = 1'b0;

  // Predictor state: loaded terms in load order, drop flag, register copies
  term_t            loaded_terms[$];
  logic             terms_dropped = 1'b0;
  logic [12:0]      src_rows      = 13'd1;
  logic [12:0]      src_cols      = 13'd1;

  in_item_t         pending_items[$];
  out_item_t        transposed_q[$];
  out_item_t        expected_term;

  int unsigned      items_queued, items_accepted, matrices_done;
  int unsigned      results_checked, overflow_results, cfg_writes, errors;
  int unsigned      send_wait, recv_wait, next_hold_at, cycle_count;
  int unsigned      hold_asked, hold_seen, hold_left;
  bit               send_burst, recv_burst;

  sparse_triplet_transpose i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  assign out_stall_i = recv_stall || hold_stall;

  // Load one accepted item; on the end marker, produce the transposed terms
  task automatic load_and_transpose(input in_item_t it);
    term_t       t;
    out_item_t   res;
    int unsigned before_run;
    before_run = transposed_q.size();
    if (it.has_term) begin
      if (loaded_terms.size() < MAX_ENTRIES) begin
        t.row   = it.in_row;
        t.col   = it.in_col;
        t.value = it.in_value;
        loaded_terms.push_back(t);
      end else begin
        terms_dropped = 1'b1;
      end
    end
    if (it.last_term) begin
      for (int c = 0; c < int'(src_cols); c++) begin
        foreach (loaded_terms[i]) begin
          if (int'(loaded_terms[i].col) == c) begin
            res.out_row   = loaded_terms[i].col;
            res.out_col   = loaded_terms[i].row;
            res.out_value = loaded_terms[i].value;
            res.last_out  = 1'b0;
            res.overflow  = terms_dropped;
            transposed_q.push_back(res);
          end
        end
      end
      // final emitted term of the run carries the last flag
      if (transposed_q.size() > before_run) begin
        res = transposed_q.pop_back();
        res.last_out = 1'b1;
        transposed_q.push_back(res);
      end
      loaded_terms.delete();
      terms_dropped = 1'b0;
      matrices_done++;
    end
  endtask

  // Input driver: one item per transfer, random gaps with burst stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        load_and_transpose(in_item_i);
        items_accepted++;
        send_wait = send_burst ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and short receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (transposed_q.size() == 0) begin
          $error("unexpected transposed term: out_row %0d out_col %0d out_value %0d",
                 out_item_o.out_row, out_item_o.out_col, out_item_o.out_value);
          errors++;
        end else begin
          expected_term = transposed_q.pop_front();
          if (out_item_o.out_row !== expected_term.out_row) begin
            $error("out_row: expected %0d, actual %0d",
                   expected_term.out_row, out_item_o.out_row);
            errors++;
          end
          if (out_item_o.out_col !== expected_term.out_col) begin
            $error("out_col: expected %0d, actual %0d",
                   expected_term.out_col, out_item_o.out_col);
            errors++;
          end
          if (out_item_o.out_value !== expected_term.out_value) begin
            $error("out_value: expected %0d, actual %0d",
                   expected_term.out_value, out_item_o.out_value);
            errors++;
          end
          if (out_item_o.last_out !== expected_term.last_out) begin
            $error("last_out: expected %0d, actual %0d",
                   expected_term.last_out, out_item_o.last_out);
            errors++;
          end
          if (out_item_o.overflow !== expected_term.overflow) begin
            $error("overflow: expected %0d, actual %0d",
                   expected_term.overflow, out_item_o.overflow);
            errors++;
          end
          if (expected_term.overflow) overflow_results++;
        end
        results_checked++;
        // ask for a long hold-off while the sender still has items to offer
        if ((pending_items.size() > 0 || in_valid_i) && results_checked >= next_hold_at) begin
          hold_asked   <= hold_asked + 1;
          next_hold_at = results_checked + 150;
        end
        recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
      end else if (out_valid_o && recv_wait > 0) begin
        recv_wait--;
      end
      recv_stall <= (recv_wait > 0);
    end
  end

  // Long hold-off, counted in clock cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_stall <= 1'b0;
      hold_left = 0;
      hold_seen = hold_asked;
    end else begin
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      hold_stall <= (hold_left > 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic has, input logic [11:0] row,
                                         input logic [11:0] col, input logic [31:0] value,
                                         input logic last);
    in_item_t it;
    it.has_term  = has;
    it.in_row    = row;
    it.in_col    = col;
    it.in_value  = value;
    it.last_term = last;
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SOURCE_ROWS: src_rows = data;
      REG_SOURCE_COLS: src_cols = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Block idle: every item accepted, every result seen, scan given time to close
  task automatic wait_idle();
    while (items_accepted != items_queued || transposed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One matrix with random content; adds its number of counted items to counted
  task automatic queue_matrix(input int n_terms, input bit out_of_scan, inout int counted);
    int          col_hi;
    logic [11:0] col;
    logic [31:0] value;
    bit          combined;
    col_hi   = (src_cols > 13'd4095) ? 4095 : int'(src_cols);
    combined = (n_terms > 0) && ($urandom_range(0, 2) != 0);
    for (int k = 0; k < n_terms; k++) begin
      // stray items that neither load nor end
      if ($urandom_range(0, 7) == 0)
        queue_item(make_item(1'b0, 12'($urandom), 12'($urandom), $urandom, 1'b0));
      if (out_of_scan)
        col = 12'($urandom_range(int'(src_cols), 4095));
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: col = 12'($urandom_range(0, col_hi));
          6:                col = '0;
          7:                col = 12'(col_hi);
          default:          col = 12'($urandom);
        endcase
      end
      case ($urandom_range(0, 11))
        0:       value = VAL_MAX;
        1:       value = VAL_MIN;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom;
      endcase
      queue_item(make_item(1'b1, 12'($urandom), col, value, combined && (k == n_terms - 1)));
      counted++;
    end
    if (!combined) begin
      queue_item(make_item(1'b0, 12'($urandom), 12'($urandom), $urandom, 1'b1));
      counted++;
    end
  endtask

  initial begin
    int          random_items;
    int          n_mat;
    logic [12:0] cols_pick;
    random_items = 0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    next_hold_at = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: stray item, empty end marker, term and end in one item
    queue_item(make_item(1'b0, 12'hfff, 12'hfff, '1, 1'b0));
    queue_item(make_item(1'b0, 12'h000, 12'h000, '0, 1'b1));
    queue_item(make_item(1'b1, 12'hfff, 12'h000, VAL_MAX, 1'b0));
    queue_item(make_item(1'b1, 12'd17, 12'h001, VAL_MIN, 1'b0));
    queue_item(make_item(1'b1, 12'h000, 12'h000, '1, 1'b1));
    wait_idle();

    // Largest matrix shape, index extremes, separate end marker
    write_reg(REG_SOURCE_ROWS, 13'd4096);
    write_reg(REG_SOURCE_COLS, 13'd4096);
    queue_item(make_item(1'b1, 12'h000, 12'hfff, '0, 1'b0));
    queue_item(make_item(1'b1, 12'hfff, 12'h800, 32'd1, 1'b0));
    queue_item(make_item(1'b1, 12'haaa, 12'h000, 32'h5555_5555, 1'b0));
    queue_item(make_item(1'b1, 12'h555, 12'hfff, 32'haaaa_aaaa, 1'b0));
    queue_item(make_item(1'b1, 12'hfff, 12'hfff, '1, 1'b0));
    queue_item(make_item(1'b0, 12'hfff, 12'hfff, '1, 1'b1));
    wait_idle();

    // Narrow scan: a run with nothing in range, then a check the store was cleared
    write_reg(REG_SOURCE_ROWS, 13'd1);
    write_reg(REG_SOURCE_COLS, 13'd3);
    write_reg(REG_SPARE_A, '0);
    write_reg(REG_SPARE_B, '0);
    queue_item(make_item(1'b1, 12'd5, 12'd3, 32'd7, 1'b0));
    queue_item(make_item(1'b1, 12'd6, 12'hfff, 32'd8, 1'b1));
    queue_item(make_item(1'b1, 12'd1, 12'd2, 32'd9, 1'b1));
    wait_idle();

    // Random phases; the first overfills the store, the second opens with a
    // matrix whose every term lies outside the scan so that run emits nothing
    for (int phase = 0; phase < 2 || random_items < RANDOM_ITEMS; phase++) begin
      case (phase)
        0:       cols_pick = 13'd4096;
        1:       cols_pick = 13'($urandom_range(1, 8));
        default: begin
          case ($urandom_range(0, 3))
            0:       cols_pick = 13'd1;
            1:       cols_pick = 13'd4096;
            2:       cols_pick = 13'($urandom_range(2, 16));
            default: cols_pick = 13'($urandom_range(1, 4096));
          endcase
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SOURCE_ROWS, 13'($urandom_range(1, 4096)));
        write_reg(REG_SOURCE_COLS, cols_pick);
      end else begin
        write_reg(REG_SOURCE_COLS, cols_pick);
        write_reg(REG_SOURCE_ROWS, 13'($urandom_range(1, 4096)));
      end
      n_mat = (phase == 0) ? 2 : $urandom_range(2, 4);
      for (int m = 0; m < n_mat; m++) begin
        if (m == 0 && phase == 0)
          queue_matrix(OVERFLOW_RUN, 1'b0, random_items);
        else if (m == 0 && phase == 1)
          queue_matrix($urandom_range(1, 12), 1'b1, random_items);
        else
          queue_matrix($urandom_range(0, 12), 1'b0, random_items);
      end
      wait_idle();
    end

    $display("Covered %0d input transfers in %0d matrices; %0d transposed terms checked,",
             items_accepted, matrices_done, results_checked);
    $display("%0d of them flagged overflow, over %0d register writes.",
             overflow_results, cfg_writes);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
